// ===== rtl/rdd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rdd_pkg;

	localparam int MAX_DIM = 4096;

	localparam int W_CFG   = 20;
	localparam int W_IDX   = 8;
	localparam int W_COORD = 12;
	localparam int W_DIST  = 32;
	localparam int W_OFF   = 20;
	localparam int W_PROD  = 40;
	localparam int W_HALF  = W_PROD / 2;
	localparam int W_NP    = W_DIST + W_HALF;
	localparam int W_S     = 82;
	localparam int W_S3    = W_S + 2;
	localparam int W_N     = 72;
	localparam int W_LIMB  = W_N / 3;
	localparam int W_LP    = 2 * W_LIMB;
	localparam int W_N2    = 2 * W_N;
	localparam int W_E     = 148;
	localparam int W_Q     = 32;

	typedef enum logic [W_IDX-1:0] {
		IDX_FOCAL_X  = 8'd0,
		IDX_FOCAL_Y  = 8'd1,
		IDX_CENTER_X = 8'd2,
		IDX_CENTER_Y = 8'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [W_CFG-1:0] fx;
		logic [W_CFG-1:0] fy;
		logic [W_CFG-1:0] cx;
		logic [W_CFG-1:0] cy;
	} rdd_cfg_t;

	typedef struct packed {
		logic            valid;
		logic [W_N2-1:0] n2;
		logic [W_S-1:0]  s;
		logic [W_S3-1:0] s3;
	} rdd_terms_t;

	typedef struct packed {
		logic           valid;
		logic [W_Q-1:0] depth;
	} rdd_res_t;

endpackage
`default_nettype wire

// ===== rtl/rdd_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rdd_cfg import rdd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [W_IDX-1:0] cfg_index,
	input  wire logic [W_CFG-1:0] cfg_data,
	output rdd_cfg_t              cfg
);

	rdd_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fx <= W_CFG'(123136);
			cfg_q.fy <= W_CFG'(123136);
			cfg_q.cx <= W_CFG'(81792);
			cfg_q.cy <= W_CFG'(61312);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				IDX_FOCAL_X: begin
					cfg_q.fx <= cfg_data;
				end
				IDX_FOCAL_Y: begin
					cfg_q.fy <= cfg_data;
				end
				IDX_CENTER_X: begin
					cfg_q.cx <= cfg_data;
				end
				IDX_CENTER_Y: begin
					cfg_q.cy <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/rdd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rdd_front import rdd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire rdd_cfg_t           cfg,
	input  wire logic               in_valid,
	input  wire logic [W_DIST-1:0]  distance,
	input  wire logic [W_COORD-1:0] pixel_col,
	input  wire logic [W_COORD-1:0] pixel_row,
	output rdd_terms_t              terms
);

	localparam logic [W_COORD-1:0] COORD_MAX = W_COORD'(MAX_DIM - 1);

	logic [W_CFG-1:0]   fxe, fye;
	logic [W_COORD-1:0] col_sat, row_sat;
	logic [W_OFF-1:0]   px, py, ax, ay;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic [W_OFF-1:0]  ax_s1, ay_s1;
	logic [W_DIST-1:0] dist_s1, dist_s2;
	logic [W_PROD-1:0] pa_s2, pb_s2, pf_s2;

	logic [W_PROD-1:0] ahh_s3, ahl_s3, all_s3;
	logic [W_PROD-1:0] bhh_s3, bhl_s3, bll_s3;
	logic [W_PROD-1:0] fhh_s3, fhl_s3, fll_s3;
	logic [W_NP-1:0]   nh_s3, nl_s3;

	logic [W_S-1:0]    s_s4, s_s5, s_s6;
	logic [W_N-1:0]    n_s4;
	logic [W_S3-1:0]   s3_s5, s3_s6;
	logic [W_LP-1:0]   p00_s5, p11_s5, p22_s5, p01_s5, p02_s5, p12_s5;
	logic [W_N2-1:0]   n2_s6;

	logic [W_S-1:0]    s_sum;
	logic [W_N-1:0]    n_sum;
	logic [W_N2-1:0]   n2_sum;

	always_comb begin
		fxe = (cfg.fx == '0) ? W_CFG'(1) : cfg.fx;
		fye = (cfg.fy == '0) ? W_CFG'(1) : cfg.fy;
		col_sat = (pixel_col > COORD_MAX) ? COORD_MAX : pixel_col;
		row_sat = (pixel_row > COORD_MAX) ? COORD_MAX : pixel_row;
		px = {col_sat, 8'd0};
		py = {row_sat, 8'd0};
		ax = (px >= cfg.cx) ? px - cfg.cx : cfg.cx - px;
		ay = (py >= cfg.cy) ? py - cfg.cy : cfg.cy - py;
	end

	always_comb begin
		s_sum = (W_S'(ahh_s3) << 40) + (W_S'(ahl_s3) << 21) + W_S'(all_s3)
			+ (W_S'(bhh_s3) << 40) + (W_S'(bhl_s3) << 21) + W_S'(bll_s3)
			+ (W_S'(fhh_s3) << 40) + (W_S'(fhl_s3) << 21) + W_S'(fll_s3);
		n_sum = (W_N'(nh_s3) << W_HALF) + W_N'(nl_s3);
		n2_sum = W_N2'(p00_s5)
			+ (W_N2'(p01_s5) << (W_LIMB + 1))
			+ (W_N2'(p11_s5) << (2 * W_LIMB))
			+ (W_N2'(p02_s5) << (2 * W_LIMB + 1))
			+ (W_N2'(p12_s5) << (3 * W_LIMB + 1))
			+ (W_N2'(p22_s5) << (4 * W_LIMB));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1   <= ax;
			ay_s1   <= ay;
			dist_s1 <= distance;

			pa_s2   <= W_PROD'(fye) * W_PROD'(ax_s1);
			pb_s2   <= W_PROD'(fxe) * W_PROD'(ay_s1);
			pf_s2   <= W_PROD'(fxe) * W_PROD'(fye);
			dist_s2 <= dist_s1;

			ahh_s3 <= W_PROD'(pa_s2[W_PROD-1:W_HALF]) * W_PROD'(pa_s2[W_PROD-1:W_HALF]);
			ahl_s3 <= W_PROD'(pa_s2[W_PROD-1:W_HALF]) * W_PROD'(pa_s2[W_HALF-1:0]);
			all_s3 <= W_PROD'(pa_s2[W_HALF-1:0]) * W_PROD'(pa_s2[W_HALF-1:0]);
			bhh_s3 <= W_PROD'(pb_s2[W_PROD-1:W_HALF]) * W_PROD'(pb_s2[W_PROD-1:W_HALF]);
			bhl_s3 <= W_PROD'(pb_s2[W_PROD-1:W_HALF]) * W_PROD'(pb_s2[W_HALF-1:0]);
			bll_s3 <= W_PROD'(pb_s2[W_HALF-1:0]) * W_PROD'(pb_s2[W_HALF-1:0]);
			fhh_s3 <= W_PROD'(pf_s2[W_PROD-1:W_HALF]) * W_PROD'(pf_s2[W_PROD-1:W_HALF]);
			fhl_s3 <= W_PROD'(pf_s2[W_PROD-1:W_HALF]) * W_PROD'(pf_s2[W_HALF-1:0]);
			fll_s3 <= W_PROD'(pf_s2[W_HALF-1:0]) * W_PROD'(pf_s2[W_HALF-1:0]);
			nh_s3  <= W_NP'(dist_s2) * W_NP'(pf_s2[W_PROD-1:W_HALF]);
			nl_s3  <= W_NP'(dist_s2) * W_NP'(pf_s2[W_HALF-1:0]);

			s_s4 <= s_sum;
			n_s4 <= n_sum;

			s_s5   <= s_s4;
			s3_s5  <= W_S3'(s_s4) + (W_S3'(s_s4) << 1);
			p00_s5 <= W_LP'(n_s4[W_LIMB-1:0]) * W_LP'(n_s4[W_LIMB-1:0]);
			p11_s5 <= W_LP'(n_s4[2*W_LIMB-1:W_LIMB]) * W_LP'(n_s4[2*W_LIMB-1:W_LIMB]);
			p22_s5 <= W_LP'(n_s4[W_N-1:2*W_LIMB]) * W_LP'(n_s4[W_N-1:2*W_LIMB]);
			p01_s5 <= W_LP'(n_s4[W_LIMB-1:0]) * W_LP'(n_s4[2*W_LIMB-1:W_LIMB]);
			p02_s5 <= W_LP'(n_s4[W_LIMB-1:0]) * W_LP'(n_s4[W_N-1:2*W_LIMB]);
			p12_s5 <= W_LP'(n_s4[2*W_LIMB-1:W_LIMB]) * W_LP'(n_s4[W_N-1:2*W_LIMB]);

			s_s6  <= s_s5;
			s3_s6 <= s3_s5;
			n2_s6 <= n2_sum;
		end
	end

	assign terms.valid = v_s6;
	assign terms.n2    = n2_s6;
	assign terms.s     = s_s6;
	assign terms.s3    = s3_s6;

endmodule
`default_nettype wire

// ===== rtl/rdd_root.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rdd_root import rdd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire rdd_terms_t terms,
	output rdd_res_t        res
);

	// One result bit per stage. rem holds N*N - q*q*S, e holds the growth of
	// q*q*S if the current bit were set.
	logic [W_E-1:0]  rem_s [0:W_Q];
	logic [W_E-1:0]  e_s   [0:W_Q];
	logic [W_S-1:0]  s_s   [0:W_Q];
	logic [W_S3-1:0] s3_s  [0:W_Q];
	logic [W_Q-1:0]  q_s   [0:W_Q];
	logic            v_s   [0:W_Q];

	assign rem_s[0] = W_E'(terms.n2);
	assign e_s[0]   = W_E'(terms.s) << (2 * (W_Q - 1));
	assign s_s[0]   = terms.s;
	assign s3_s[0]  = terms.s3;
	assign q_s[0]   = '0;
	assign v_s[0]   = terms.valid;

	for (genvar k = 0; k < W_Q; k++) begin : g_bit
		localparam int B = W_Q - 1 - k;

		logic [W_E:0]   diff;
		logic           ok;
		logic [W_E-1:0] e_half, e_next;

		assign diff   = {1'b0, rem_s[k]} - {1'b0, e_s[k]};
		assign ok     = ~diff[W_E];
		assign e_half = e_s[k] >> 1;

		if (B > 0) begin : g_next
			assign e_next = ok ? e_half + (W_E'(s3_s[k]) << (2 * B - 2))
				: e_half - (W_E'(s_s[k]) << (2 * B - 2));
		end else begin : g_last
			assign e_next = e_half;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ok ? diff[W_E-1:0] : rem_s[k];
				e_s[k+1]   <= e_next;
				s_s[k+1]   <= s_s[k];
				s3_s[k+1]  <= s3_s[k];
				q_s[k+1]   <= {q_s[k][W_Q-2:0], ok};
			end
		end
	end

	assign res.valid = v_s[W_Q];
	assign res.depth = q_s[W_Q];

endmodule
`default_nettype wire

// ===== rtl/rdd_out.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rdd_out import rdd_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire rdd_res_t res,
	output logic          en,
	output logic          out_valid,
	input  wire logic     out_stall,
	output logic [W_Q-1:0] depth
);

	logic           out_valid_q, skid_full_q, out_free;
	logic [W_Q-1:0] depth_q, skid_q;

	// The pipeline keeps moving until the skid entry is taken, so a result
	// leaving the last stage always has a place to go.
	assign en        = ~skid_full_q;
	assign out_free  = ~out_valid_q | ~out_stall;
	assign out_valid = out_valid_q;
	assign depth     = depth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= skid_full_q | res.valid;
			skid_full_q <= 1'b0;
		end else if (res.valid && en) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			depth_q <= skid_full_q ? skid_q : res.depth;
		end else if (res.valid && en) begin
			skid_q <= res.depth;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ray_distance_to_depth_unit.sv =====
// Pipeline: 6 product stages, 32 root stages and one output register lie between
// an input transfer and the result on the output port.
// Throughput: one item per cycle while in_stall is low; each root stage settles one result bit.
// Reset: asynchronous, active low; clears all valid bits and the skid entry
// and loads the camera registers with their default intrinsics.
`timescale 1ns / 1ps
`default_nettype none
module ray_distance_to_depth_unit import rdd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [W_DIST-1:0]  distance,
	input  wire logic [W_COORD-1:0] pixel_col,
	input  wire logic [W_COORD-1:0] pixel_row,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [W_Q-1:0]          depth,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [W_IDX-1:0]   cfg_index,
	input  wire logic [W_CFG-1:0]   cfg_data
);

	rdd_cfg_t   cfg;
	rdd_terms_t terms;
	rdd_res_t   res;
	logic       en;

	assign in_stall = ~en;

	rdd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rdd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.distance  (distance),
		.pixel_col (pixel_col),
		.pixel_row (pixel_row),
		.terms     (terms)
	);

	rdd_root u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.terms  (terms),
		.res    (res)
	);

	rdd_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.en        (en),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.depth     (depth)
	);

endmodule
`default_nettype wire

// ===== tb/sv/tb_ray_distance_to_depth_unit.sv =====
`timescale 1ns / 1ps
module tb_ray_distance_to_depth_unit;
	import rdd_pkg::*;

	localparam logic [W_IDX-1:0] IDX_UNUSED = 8'hA5;
	localparam int DRAIN_CYCLES = 60;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int RING_DEPTH = 1024;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [W_DIST-1:0] distance;
	logic [W_COORD-1:0] pixel_col;
	logic [W_COORD-1:0] pixel_row;
	logic out_valid;
	logic out_stall;
	logic [W_Q-1:0] depth;
	logic cfg_valid;
	logic cfg_ready;
	logic [W_IDX-1:0] cfg_index;
	logic [W_CFG-1:0] cfg_data;

	logic [W_CFG-1:0] cam_fx, cam_fy, cam_cx, cam_cy;
	logic [W_Q-1:0] want_ring [0:RING_DEPTH-1];
	int want_wr;
	int want_rd;
	int mismatches;
	int failures;
	int idle_cycles;
	bit sender_gaps;
	bit receiver_gaps;
	int hold_requests;

	ray_distance_to_depth_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.distance(distance), .pixel_col(pixel_col), .pixel_row(pixel_row),
		.out_valid(out_valid), .out_stall(out_stall), .depth(depth),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Exact planar depth: the largest q with q*q*S <= N*N.
	function automatic logic [W_Q-1:0] planar_depth(logic [W_DIST-1:0] ray_len,
			logic [W_COORD-1:0] col, logic [W_COORD-1:0] row);
		logic [159:0] fx, fy, px, py, ax, ay, s, n2, c;
		logic [W_Q-1:0] q;
		logic [W_Q-1:0] cand;
		fx = (cam_fx == 0) ? 160'd1 : 160'(cam_fx);
		fy = (cam_fy == 0) ? 160'd1 : 160'(cam_fy);
		px = 160'(col) * 256;
		py = 160'(row) * 256;
		ax = (px >= 160'(cam_cx)) ? px - 160'(cam_cx) : 160'(cam_cx) - px;
		ay = (py >= 160'(cam_cy)) ? py - 160'(cam_cy) : 160'(cam_cy) - py;
		s = ax * ax * fy * fy + ay * ay * fx * fx + fx * fx * fy * fy;
		n2 = 160'(ray_len) * fx * fy;
		n2 = n2 * n2;
		q = '0;
		for (int b = W_Q - 1; b >= 0; b--) begin
			cand = q | (32'd1 << b);
			c = 160'(cand);
			if (c * c * s <= n2) begin
				q = cand;
			end
		end
		return q;
	endfunction

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			want_ring[want_wr % RING_DEPTH] = planar_depth(distance, pixel_col, pixel_row);
			want_wr++;
		end
	end

	always @(posedge clk) begin
		logic [W_Q-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (want_wr == want_rd) begin
				failures++;
				if (mismatches < 10) begin
					$display("Unexpected depth transfer: %0d", depth);
				end
				mismatches++;
			end else begin
				want = want_ring[want_rd % RING_DEPTH];
				want_rd++;
				if (depth !== want) begin
					failures++;
					if (mismatches < 10) begin
						$display("Depth mismatch: expected %0d, got %0d", want, depth);
					end
					mismatches++;
				end
			end
		end
	end

	always @(negedge clk) begin
		int hold_left;
		int hold_seen;
		if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= receiver_gaps && ($urandom_range(99) < 27);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_pixel(logic [W_DIST-1:0] ray_len, logic [W_COORD-1:0] col,
			logic [W_COORD-1:0] row);
		@(negedge clk);
		while (sender_gaps && ($urandom_range(99) < 27)) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		distance <= ray_len;
		pixel_col <= col;
		pixel_row <= row;
		do begin
			@(posedge clk);
		end while (in_stall);
	endtask

	task automatic write_register(logic [W_IDX-1:0] idx, logic [W_CFG-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		case (idx)
			IDX_FOCAL_X: begin
				cam_fx = value;
			end
			IDX_FOCAL_Y: begin
				cam_fy = value;
			end
			IDX_CENTER_X: begin
				cam_cx = value;
			end
			IDX_CENTER_Y: begin
				cam_cy = value;
			end
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_camera(logic [W_CFG-1:0] fx, logic [W_CFG-1:0] fy,
			logic [W_CFG-1:0] cx, logic [W_CFG-1:0] cy);
		write_register(IDX_FOCAL_X, fx);
		write_register(IDX_FOCAL_Y, fy);
		write_register(IDX_CENTER_X, cx);
		write_register(IDX_CENTER_Y, cy);
	endtask

	task automatic drain;
		@(negedge clk);
		in_valid <= 1'b0;
		while (want_wr != want_rd) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [W_DIST-1:0] random_distance();
		case ($urandom_range(3))
			0: return $urandom_range(65535);
			1: return $urandom;
			2: return 32'hFFFF_FFFF - $urandom_range(255);
			default: return $urandom_range(32'h00FF_FFFF);
		endcase
	endfunction

	function automatic logic [W_COORD-1:0] random_coord();
		if ($urandom_range(9) == 0) begin
			return $urandom_range(1) ? 12'hFFF : 12'h000;
		end
		return W_COORD'($urandom_range(4095));
	endfunction

	function automatic logic [W_CFG-1:0] random_reg();
		return W_CFG'($urandom_range(20'hFFFFF));
	endfunction

	task automatic test_directed;
		send_pixel(32'd0, 12'd0, 12'd0);
		send_pixel(32'hFFFF_FFFF, 12'd0, 12'd0);
		send_pixel(32'hFFFF_FFFF, 12'd4095, 12'd4095);
		send_pixel(32'h0001_0000, 12'd319, 12'd239);
		send_pixel(32'h0001_0000, 12'd320, 12'd240);
		send_pixel(32'h0010_0000, 12'd4095, 12'd0);
		send_pixel(32'h0010_0000, 12'd0, 12'd4095);
		send_pixel(32'h0000_0001, 12'd100, 12'd100);
		send_pixel(32'hAAAA_5555, 12'hAAA, 12'h555);
		send_pixel(32'h5555_AAAA, 12'h555, 12'hAAA);
		drain();
		// A focal length of zero behaves as the smallest step.
		set_camera(20'd0, 20'd0, 20'd0, 20'd0);
		send_pixel(32'hFFFF_FFFF, 12'd0, 12'd0);
		send_pixel(32'hFFFF_FFFF, 12'd4095, 12'd4095);
		send_pixel(32'h1234_5678, 12'd1, 12'd0);
		drain();
		set_camera(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
		send_pixel(32'hFFFF_FFFF, 12'd0, 12'd0);
		send_pixel(32'hFFFF_FFFF, 12'd4095, 12'd4095);
		send_pixel(32'h0000_FFFF, 12'd2048, 12'd1);
		drain();
		// An unused register index must leave the camera untouched.
		write_register(IDX_UNUSED, 20'h00001);
		send_pixel(32'h0100_0000, 12'd10, 12'd4000);
		send_pixel(32'h0100_0000, 12'd4000, 12'd10);
		drain();
	endtask

	task automatic test_random_cameras;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_camera(20'd123136, 20'd123136, 20'd81792, 20'd61312);
				1: set_camera(20'd1, 20'hFFFFF, 20'd0, 20'hFFFFF);
				2: set_camera(20'hFFFFF, 20'd1, 20'hFFFFF, 20'd0);
				default: set_camera(random_reg(), random_reg(), random_reg(), random_reg());
			endcase
			sender_gaps = (phase != 3);
			receiver_gaps = (phase != 3);
			for (int i = 0; i < 260; i++) begin
				send_pixel(random_distance(), random_coord(), random_coord());
			end
			drain();
		end
		sender_gaps = 1'b1;
		receiver_gaps = 1'b1;
	endtask

	task automatic test_backpressure;
		sender_gaps = 1'b0;
		@(negedge clk);
		hold_requests++;
		for (int i = 0; i < 120; i++) begin
			send_pixel(random_distance(), random_coord(), random_coord());
		end
		sender_gaps = 1'b1;
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		distance = '0;
		pixel_col = '0;
		pixel_row = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		out_stall = 1'b0;
		sender_gaps = 1'b1;
		receiver_gaps = 1'b1;
		hold_requests = 0;
		want_wr = 0;
		want_rd = 0;
		mismatches = 0;
		failures = 0;
		idle_cycles = 0;
		cam_fx = 20'd123136;
		cam_fy = 20'd123136;
		cam_cx = 20'd81792;
		cam_cy = 20'd61312;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_cameras();
		test_backpressure();

		if (failures == 0 && want_wr == want_rd) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
